FILE: rtl/ttps_pkg.sv
package ttps_pkg;

	// fixed field widths
	localparam int KEY_W   = 64;
	localparam int DEPTH_W = 8;
	localparam int FLAG_W  = 2;
	localparam int MOVE_W  = 16;
	localparam int MASK_W  = 12;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// defaults for the top level parameters
	localparam int INDEX_BITS_DEF = 12;
	localparam int EVAL_BITS_DEF  = 16;

	// register reset values
	localparam logic              ENABLE_RST = 1'b1;
	localparam logic [MASK_W-1:0] MASK_RST   = 12'hfff;

	// register indexes (byte address bit 2)
	localparam logic REG_TABLE_ENABLE = 1'b0;
	localparam logic REG_INDEX_MASK   = 1'b1;

	// command codes
	localparam logic CMD_PROBE = 1'b0;
	localparam logic CMD_SAVE  = 1'b1;

	// bound kinds
	localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_ALPHA = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_BETA  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;    // capture the request word and start the entry read
		logic clr_wr;  // write one cleared entry of the reset sweep
		logic commit;  // write back the entry and load the response register
	} ttps_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;  // sweep counter sits on the last entry
		logic rsp_free;  // response register can take a word this cycle
	} ttps_stat_t;

endpackage

FILE: rtl/ttps_ram.sv
module ttps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port that holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/ttps_ctrl.sv
module ttps_ctrl
	import ttps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  ttps_stat_t stat,
	output ttps_cmd_t  ctl
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_LOOK  = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	// next state and commands
	always_comb begin
		state_nxt    = state_q;
		ctl          = '0;
		req_ready    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (stat.rsp_free) begin
					ctl.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: rtl/ttps_dp.sv
module ttps_dp
	import ttps_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int EVAL_BITS  = EVAL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// controller link
	input  ttps_cmd_t                   ctl,
	output ttps_stat_t                  stat,
	// request word
	input  logic                        cmd,
	input  logic [KEY_W-1:0]            key,
	input  logic [DEPTH_W-1:0]          depth,
	input  logic signed [EVAL_BITS-1:0] alpha,
	input  logic signed [EVAL_BITS-1:0] beta,
	input  logic signed [EVAL_BITS-1:0] eval,
	input  logic [FLAG_W-1:0]           flag,
	input  logic [MOVE_W-1:0]           best_move,
	// response word
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        hit,
	output logic signed [EVAL_BITS-1:0] out_eval,
	output logic [DEPTH_W-1:0]          out_depth,
	output logic [FLAG_W-1:0]           out_flag,
	output logic [MOVE_W-1:0]           out_move,
	output logic [KEY_W-1:0]            out_key,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [APB_AW-1:0]           paddr,
	input  logic [APB_DW-1:0]           pwdata,
	output logic [APB_DW-1:0]           prdata
);

	localparam int DEPTH   = 1 << INDEX_BITS;
	// entry layout, low to high: move, flag, eval, depth, key, valid
	localparam int FLAG_LO  = MOVE_W;
	localparam int EVAL_LO  = FLAG_LO + FLAG_W;
	localparam int DEPTH_LO = EVAL_LO + EVAL_BITS;
	localparam int KEY_LO   = DEPTH_LO + DEPTH_W;
	localparam int VALID_B  = KEY_LO + KEY_W;
	localparam int ENTRY_W  = VALID_B + 1;

	// configuration registers
	logic              enable_q;
	logic [MASK_W-1:0] index_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= ENABLE_RST;
			index_mask_q <= MASK_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_TABLE_ENABLE: enable_q     <= pwdata[0];
				REG_INDEX_MASK:   index_mask_q <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[2])
			REG_TABLE_ENABLE: prdata = APB_DW'(enable_q);
			REG_INDEX_MASK:   prdata = APB_DW'(index_mask_q);
			default:          prdata = '0;
		endcase
	end

	// mask bits beyond the table are dropped, missing ones read as zero
	logic [INDEX_BITS-1:0] mask_ext;
	for (genvar g = 0; g < INDEX_BITS; g++) begin : g_mask
		if (g < MASK_W) begin : g_in
			assign mask_ext[g] = index_mask_q[g];
		end else begin : g_out
			assign mask_ext[g] = 1'b0;
		end
	end

	logic [INDEX_BITS-1:0] rd_idx;
	assign rd_idx = key[INDEX_BITS-1:0] & mask_ext;

	// captured request word
	logic                        cmd_q;
	logic [KEY_W-1:0]            key_q;
	logic [DEPTH_W-1:0]          depth_q;
	logic signed [EVAL_BITS-1:0] alpha_q;
	logic signed [EVAL_BITS-1:0] beta_q;
	logic signed [EVAL_BITS-1:0] eval_q;
	logic [FLAG_W-1:0]           flag_q;
	logic [MOVE_W-1:0]           move_q;
	logic [INDEX_BITS-1:0]       idx_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			key_q   <= key;
			depth_q <= depth;
			alpha_q <= alpha;
			beta_q  <= beta;
			eval_q  <= eval;
			flag_q  <= flag;
			move_q  <= best_move;
			idx_q   <= rd_idx;
		end
	end

	// reset sweep counter
	logic [INDEX_BITS-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign stat.clr_last = (clr_cnt_q == {INDEX_BITS{1'b1}});

	// entry memory
	logic [ENTRY_W-1:0]    rdata;
	logic [ENTRY_W-1:0]    wdata;
	logic [INDEX_BITS-1:0] waddr;
	logic                  we;
	logic                  save_wr;

	ttps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.load),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	// fields of the entry read
	logic                        e_valid;
	logic [KEY_W-1:0]            e_key;
	logic [DEPTH_W-1:0]          e_depth;
	logic signed [EVAL_BITS-1:0] e_eval;
	logic [FLAG_W-1:0]           e_flag;
	logic [MOVE_W-1:0]           e_move;

	assign e_valid = rdata[VALID_B];
	assign e_key   = rdata[KEY_LO +: KEY_W];
	assign e_depth = rdata[DEPTH_LO +: DEPTH_W];
	assign e_eval  = rdata[EVAL_LO +: EVAL_BITS];
	assign e_flag  = rdata[FLAG_LO +: FLAG_W];
	assign e_move  = rdata[MOVE_W-1:0];

	logic key_match;
	assign key_match = e_valid && (e_key == key_q);

	// a save is dropped when the same key already sits deeper
	assign save_wr = enable_q && (cmd_q == CMD_SAVE) && !(key_match && (e_depth > depth_q));

	assign we    = ctl.clr_wr || (ctl.commit && save_wr);
	assign waddr = ctl.clr_wr ? clr_cnt_q : idx_q;
	assign wdata = ctl.clr_wr ? '0 : {1'b1, key_q, depth_q, eval_q, flag_q, move_q};

	// probe result
	logic                        res_hit;
	logic signed [EVAL_BITS-1:0] res_eval;
	logic [DEPTH_W-1:0]          res_depth;
	logic [FLAG_W-1:0]           res_flag;
	logic [MOVE_W-1:0]           res_move;
	logic [KEY_W-1:0]            res_key;

	always_comb begin
		res_hit   = 1'b0;
		res_eval  = '0;
		res_depth = '0;
		res_flag  = '0;
		res_move  = '0;
		res_key   = '0;
		if (enable_q && (cmd_q == CMD_PROBE) && e_valid) begin
			res_eval  = e_eval;
			res_depth = e_depth;
			res_flag  = e_flag;
			res_move  = e_move;
			res_key   = e_key;
			if (key_match && (e_depth >= depth_q)) begin
				case (e_flag)
					FLAG_EXACT: begin
						res_hit = 1'b1;
					end
					FLAG_ALPHA: begin
						res_hit = 1'b1;
						if (alpha_q > e_eval) begin
							res_eval = alpha_q;
						end
					end
					FLAG_BETA: begin
						res_hit = 1'b1;
						if (beta_q < e_eval) begin
							res_eval = beta_q;
						end
					end
					default: begin
						res_hit = 1'b0;
					end
				endcase
			end
		end
	end

	// response register
	logic rsp_valid_q;

	assign stat.rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	logic                        hit_q;
	logic signed [EVAL_BITS-1:0] out_eval_q;
	logic [DEPTH_W-1:0]          out_depth_q;
	logic [FLAG_W-1:0]           out_flag_q;
	logic [MOVE_W-1:0]           out_move_q;
	logic [KEY_W-1:0]            out_key_q;

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			hit_q       <= res_hit;
			out_eval_q  <= res_eval;
			out_depth_q <= res_depth;
			out_flag_q  <= res_flag;
			out_move_q  <= res_move;
			out_key_q   <= res_key;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign out_eval  = out_eval_q;
	assign out_depth = out_depth_q;
	assign out_flag  = out_flag_q;
	assign out_move  = out_move_q;
	assign out_key   = out_key_q;

endmodule

FILE: rtl/transposition_table_probe_save.sv
// channel   | handshake              | word
// ----------+------------------------+----------------------------------------------
// request   | req_valid / req_ready  | cmd key depth alpha beta eval flag best_move
// response  | rsp_valid / rsp_ready  | hit out_eval out_depth out_flag out_move out_key
// registers | psel penable pwrite    | paddr pwdata prdata pready (0 enable, 4 mask)
//
// each request runs in order through the registered entry read, then the
// compare, the write-back of a save and the load of the response register.
// after reset a sweep clears the valid bits of all 2**INDEX_BITS entries,
// one entry a cycle; req_ready stays low until it ends, register writes are
// taken throughout. a new request is taken while a response still waits; it
// then holds in its compare step until the response register frees.
module transposition_table_probe_save
	import ttps_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int EVAL_BITS  = EVAL_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        cmd,
	input  logic [KEY_W-1:0]            key,
	input  logic [DEPTH_W-1:0]          depth,
	input  logic signed [EVAL_BITS-1:0] alpha,
	input  logic signed [EVAL_BITS-1:0] beta,
	input  logic signed [EVAL_BITS-1:0] eval,
	input  logic [FLAG_W-1:0]           flag,
	input  logic [MOVE_W-1:0]           best_move,
	// response
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        hit,
	output logic signed [EVAL_BITS-1:0] out_eval,
	output logic [DEPTH_W-1:0]          out_depth,
	output logic [FLAG_W-1:0]           out_flag,
	output logic [MOVE_W-1:0]           out_move,
	output logic [KEY_W-1:0]            out_key,
	// registers
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [APB_AW-1:0]           paddr,
	input  logic [APB_DW-1:0]           pwdata,
	output logic [APB_DW-1:0]           prdata,
	output logic                        pready
);

	ttps_cmd_t  ctl_cmd;
	ttps_stat_t dp_stat;

	assign pready = 1'b1;

	// sequencer
	ttps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (dp_stat),
		.ctl       (ctl_cmd)
	);

	// table, compare and response register
	ttps_dp #(
		.INDEX_BITS (INDEX_BITS),
		.EVAL_BITS  (EVAL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_cmd),
		.stat      (dp_stat),
		.cmd       (cmd),
		.key       (key),
		.depth     (depth),
		.alpha     (alpha),
		.beta      (beta),
		.eval      (eval),
		.flag      (flag),
		.best_move (best_move),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.hit       (hit),
		.out_eval  (out_eval),
		.out_depth (out_depth),
		.out_flag  (out_flag),
		.out_move  (out_move),
		.out_key   (out_key),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata)
	);

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
	import ttps_pkg::*;

	localparam int INDEX_W        = INDEX_BITS_DEF;
	localparam int EVAL_W         = EVAL_BITS_DEF;
	localparam int SLOT_COUNT     = 1 << INDEX_W;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 160;

	localparam logic [EVAL_W-1:0] EVAL_MIN = {1'b1, {(EVAL_W-1){1'b0}}};
	localparam logic [EVAL_W-1:0] EVAL_MAX = {1'b0, {(EVAL_W-1){1'b1}}};
	localparam logic [FLAG_W-1:0] FLAG_NONE = 2'd3;

	localparam logic [KEY_W-1:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic [KEY_W-1:0] KEY_A    = 64'h0123_4567_89ab_c001;
	localparam logic [KEY_W-1:0] KEY_A2   = 64'h8123_4567_89ab_c001;
	localparam logic [KEY_W-1:0] KEY_B    = 64'hfedc_ba98_7654_3002;
	localparam logic [KEY_W-1:0] KEY_C    = 64'h5a5a_a5a5_0f0f_f003;

	typedef struct packed {
		logic                cmd;
		logic [KEY_W-1:0]    key;
		logic [DEPTH_W-1:0]  depth;
		logic [EVAL_W-1:0]   alpha;
		logic [EVAL_W-1:0]   beta;
		logic [EVAL_W-1:0]   eval;
		logic [FLAG_W-1:0]   flag;
		logic [MOVE_W-1:0]   move;
	} tt_req_t;

	typedef struct packed {
		logic                hit;
		logic [EVAL_W-1:0]   eval;
		logic [DEPTH_W-1:0]  depth;
		logic [FLAG_W-1:0]   flag;
		logic [MOVE_W-1:0]   move;
		logic [KEY_W-1:0]    key;
	} tt_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        req_valid = 1'b0;
	logic                        req_ready;
	logic                        cmd = CMD_PROBE;
	logic [KEY_W-1:0]            key = '0;
	logic [DEPTH_W-1:0]          depth = '0;
	logic signed [EVAL_W-1:0]    alpha = '0;
	logic signed [EVAL_W-1:0]    beta = '0;
	logic signed [EVAL_W-1:0]    eval = '0;
	logic [FLAG_W-1:0]           flag = '0;
	logic [MOVE_W-1:0]           best_move = '0;

	logic                        rsp_valid;
	logic                        rsp_ready = 1'b0;
	logic                        hit;
	logic signed [EVAL_W-1:0]    out_eval;
	logic [DEPTH_W-1:0]          out_depth;
	logic [FLAG_W-1:0]           out_flag;
	logic [MOVE_W-1:0]           out_move;
	logic [KEY_W-1:0]            out_key;

	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [APB_AW-1:0]           paddr = '0;
	logic [APB_DW-1:0]           pwdata = '0;
	logic [APB_DW-1:0]           prdata;
	logic                        pready;

	// words waiting to be sent, and responses still owed by the table
	tt_req_t pending_req[$];
	tt_rsp_t expected_rsp[$];
	logic [KEY_W-1:0] key_pool[$];

	// shadow copy of the table and its registers
	logic               cfg_enable;
	logic [MASK_W-1:0]  cfg_mask;
	logic               slot_valid [SLOT_COUNT];
	logic [KEY_W-1:0]   slot_key   [SLOT_COUNT];
	logic [DEPTH_W-1:0] slot_depth [SLOT_COUNT];
	logic [EVAL_W-1:0]  slot_eval  [SLOT_COUNT];
	logic [FLAG_W-1:0]  slot_flag  [SLOT_COUNT];
	logic [MOVE_W-1:0]  slot_move  [SLOT_COUNT];

	int mismatches = 0;

	transposition_table_probe_save #(
		.INDEX_BITS(INDEX_W),
		.EVAL_BITS(EVAL_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.key(key),
		.depth(depth),
		.alpha(alpha),
		.beta(beta),
		.eval(eval),
		.flag(flag),
		.best_move(best_move),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.hit(hit),
		.out_eval(out_eval),
		.out_depth(out_depth),
		.out_flag(out_flag),
		.out_move(out_move),
		.out_key(out_key),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// probe or save against the shadow table, returns the response word
	function automatic tt_rsp_t table_access(tt_req_t q);
		tt_rsp_t r;
		logic [MASK_W-1:0] idx;
		logic signed [EVAL_W-1:0] e;
		r = '0;
		idx = q.key[MASK_W-1:0] & cfg_mask & MASK_W'(SLOT_COUNT - 1);
		if (!cfg_enable)
			return r;
		if (q.cmd == CMD_SAVE) begin
			// a deeper entry for the same position is kept
			if (!(slot_valid[idx] && slot_key[idx] == q.key && slot_depth[idx] > q.depth)) begin
				slot_valid[idx] = 1'b1;
				slot_key[idx]   = q.key;
				slot_depth[idx] = q.depth;
				slot_eval[idx]  = q.eval;
				slot_flag[idx]  = q.flag;
				slot_move[idx]  = q.move;
			end
			return r;
		end
		if (!slot_valid[idx])
			return r;
		e = $signed(slot_eval[idx]);
		if (slot_key[idx] == q.key && slot_depth[idx] >= q.depth) begin
			case (slot_flag[idx])
				FLAG_EXACT: r.hit = 1'b1;
				FLAG_ALPHA: begin
					if ($signed(q.alpha) > e)
						e = $signed(q.alpha);
					r.hit = 1'b1;
				end
				FLAG_BETA: begin
					if ($signed(q.beta) < e)
						e = $signed(q.beta);
					r.hit = 1'b1;
				end
				default: ;
			endcase
		end
		r.eval  = e;
		r.depth = slot_depth[idx];
		r.flag  = slot_flag[idx];
		r.move  = slot_move[idx];
		r.key   = slot_key[idx];
		return r;
	endfunction

	// request driver: bursts of words with random gaps
	tt_req_t cur_req;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp.push_back(table_access(cur_req));
			if (!req_valid || req_ready) begin
				if (gap_left > 0 || pending_req.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					req_valid <= 1'b0;
				end else begin
					cur_req = pending_req.pop_front();
					cmd       <= cur_req.cmd;
					key       <= cur_req.key;
					depth     <= cur_req.depth;
					alpha     <= cur_req.alpha;
					beta      <= cur_req.beta;
					eval      <= cur_req.eval;
					flag      <= cur_req.flag;
					best_move <= cur_req.move;
					req_valid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// response monitor with its own stall pattern
	int stall_span = 0;
	int stall_mode = 0;
	tt_rsp_t want_rsp;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("response word with nothing expected");
					mismatches++;
				end else begin
					want_rsp = expected_rsp.pop_front();
					check_field("hit", 64'(want_rsp.hit), 64'(hit));
					check_field("out_eval", 64'(want_rsp.eval), 64'($unsigned(out_eval)));
					check_field("out_depth", 64'(want_rsp.depth), 64'(out_depth));
					check_field("out_flag", 64'(want_rsp.flag), 64'(out_flag));
					check_field("out_move", 64'(want_rsp.move), 64'(out_move));
					check_field("out_key", want_rsp.key, out_key);
				end
			end
			if (stall_span == 0) begin
				stall_span = $urandom_range(8, 64);
				stall_mode = $urandom_range(0, 3);
			end
			stall_span--;
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 1) == 0);
				2: rsp_ready <= ($urandom_range(0, 3) != 0);
				default: rsp_ready <= (stall_span % 5 == 0);
			endcase
		end
	end

	// watchdog on cycles without any accepted word
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic apb_write(logic reg_idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_TABLE_ENABLE)
			cfg_enable = value[0];
		else
			cfg_mask = value[MASK_W-1:0];
	endtask

	task automatic set_config(logic en, logic [MASK_W-1:0] mask);
		apb_write(REG_TABLE_ENABLE, APB_DW'(en));
		apb_write(REG_INDEX_MASK, APB_DW'(mask));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_req(logic c, logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
			logic [EVAL_W-1:0] a, logic [EVAL_W-1:0] b, logic [EVAL_W-1:0] ev,
			logic [FLAG_W-1:0] f, logic [MOVE_W-1:0] mv);
		tt_req_t q;
		q.cmd = c;
		q.key = k;
		q.depth = d;
		q.alpha = a;
		q.beta = b;
		q.eval = ev;
		q.flag = f;
		q.move = mv;
		pending_req.push_back(q);
	endtask

	function automatic logic [EVAL_W-1:0] rand_eval();
		case ($urandom_range(0, 7))
			0: return EVAL_MIN;
			1: return EVAL_MAX;
			2: return '0;
			default: return EVAL_W'($urandom);
		endcase
	endfunction

	// a few positions, half of them colliding on the index of another
	task automatic fill_key_pool();
		logic [KEY_W-1:0] k;
		key_pool.delete();
		repeat (12)
			key_pool.push_back({$urandom, $urandom});
		repeat (12) begin
			k = key_pool[$urandom_range(0, 11)];
			k[KEY_W-1:MASK_W] = (KEY_W - MASK_W)'({$urandom, $urandom});
			key_pool.push_back(k);
		end
	endtask

	// mostly pool positions so saves are probed back; often a save is followed by its probe
	task automatic queue_random(int n);
		tt_req_t q;
		int left;
		left = n;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0)
				q.key = {$urandom, $urandom};
			else
				q.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			q.cmd   = ($urandom_range(0, 1) == 0) ? CMD_PROBE : CMD_SAVE;
			q.depth = ($urandom_range(0, 7) == 0) ? DEPTH_W'($urandom) : DEPTH_W'($urandom_range(0, 12));
			q.alpha = rand_eval();
			q.beta  = rand_eval();
			q.eval  = rand_eval();
			q.flag  = FLAG_W'($urandom_range(0, 3));
			q.move  = MOVE_W'($urandom);
			pending_req.push_back(q);
			left--;
			if (q.cmd == CMD_SAVE && left > 0 && $urandom_range(0, 1) == 1) begin
				q.cmd   = CMD_PROBE;
				q.depth = DEPTH_W'($urandom_range(0, q.depth));
				q.alpha = rand_eval();
				q.beta  = rand_eval();
				q.eval  = rand_eval();
				q.flag  = FLAG_W'($urandom_range(0, 3));
				q.move  = MOVE_W'($urandom);
				pending_req.push_back(q);
				left--;
			end
		end
	endtask

	task automatic run_phase(logic en, logic [MASK_W-1:0] mask);
		wait_idle();
		set_config(en, mask);
		fill_key_pool();
		queue_random(PHASE_ITEMS);
	endtask

	initial begin
		cfg_enable = ENABLE_RST;
		cfg_mask = MASK_RST;
		foreach (slot_valid[i])
			slot_valid[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// registers are taken during the clearing sweep
		set_config(1'b1, 12'hfff);

		// empty entry, then exact entry at the field extremes
		queue_req(CMD_PROBE, '0, '0, '0, '0, '0, FLAG_EXACT, '0);
		queue_req(CMD_SAVE, KEY_ONES, 8'hff, '0, '0, EVAL_MAX, FLAG_EXACT, 16'hffff);
		queue_req(CMD_PROBE, KEY_ONES, 8'hff, EVAL_MIN, EVAL_MAX, '0, FLAG_EXACT, '0);
		queue_req(CMD_PROBE, KEY_ONES, '0, EVAL_MAX, EVAL_MIN, '0, FLAG_EXACT, '0);
		// lower bound entry: clamp up to alpha, too shallow, other key on the index
		queue_req(CMD_SAVE, KEY_A, 8'd10, '0, '0, -16'sd100, FLAG_ALPHA, 16'h1234);
		queue_req(CMD_PROBE, KEY_A, 8'd10, EVAL_MIN, '0, '0, FLAG_EXACT, '0);
		queue_req(CMD_PROBE, KEY_A, 8'd3, EVAL_MAX, '0, '0, FLAG_EXACT, '0);
		queue_req(CMD_PROBE, KEY_A, 8'd11, '0, '0, '0, FLAG_EXACT, '0);
		queue_req(CMD_PROBE, KEY_A2, '0, '0, '0, '0, FLAG_EXACT, '0);
		// upper bound entry: clamp down to beta
		queue_req(CMD_SAVE, KEY_B, 8'd7, '0, '0, 16'sd50, FLAG_BETA, 16'h00aa);
		queue_req(CMD_PROBE, KEY_B, 8'd7, '0, EVAL_MAX, '0, FLAG_EXACT, '0);
		queue_req(CMD_PROBE, KEY_B, '0, '0, EVAL_MIN, '0, FLAG_EXACT, '0);
		// unknown bound kind never hits
		queue_req(CMD_SAVE, KEY_C, 8'd20, '0, '0, 16'sd9, FLAG_NONE, 16'h5555);
		queue_req(CMD_PROBE, KEY_C, '0, '0, '0, '0, FLAG_EXACT, '0);
		// shallower save of the same key is dropped, equal depth replaces
		queue_req(CMD_SAVE, KEY_A, 8'd4, '0, '0, 16'sd777, FLAG_EXACT, 16'h0777);
		queue_req(CMD_PROBE, KEY_A, '0, '0, '0, '0, FLAG_EXACT, '0);
		queue_req(CMD_SAVE, KEY_A, 8'd10, '0, '0, 16'sd777, FLAG_EXACT, 16'h0778);
		queue_req(CMD_PROBE, KEY_A, 8'd10, '0, '0, '0, FLAG_EXACT, '0);
		// another key on the same index replaces even a deeper entry
		queue_req(CMD_SAVE, KEY_A2, '0, '0, '0, -16'sd1, FLAG_BETA, 16'h8001);
		queue_req(CMD_PROBE, KEY_A2, '0, '0, '0, '0, FLAG_EXACT, '0);
		queue_req(CMD_SAVE, '0, '0, '0, '0, EVAL_MIN, FLAG_EXACT, '0);
		queue_req(CMD_PROBE, '0, '0, '0, '0, '0, FLAG_EXACT, '0);

		run_phase(1'b1, 12'hfff);
		run_phase(1'b1, 12'h00f);
		run_phase(1'b1, 12'h000);

		// disabled table: nothing shows and nothing is written
		wait_idle();
		set_config(1'b0, 12'hfff);
		queue_req(CMD_SAVE, KEY_ONES, 8'hff, '0, '0, 16'sd1, FLAG_BETA, 16'h0001);
		queue_req(CMD_PROBE, KEY_ONES, '0, '0, '0, '0, FLAG_EXACT, '0);
		fill_key_pool();
		queue_random(PHASE_ITEMS);

		run_phase(1'b1, 12'h0ff);
		queue_req(CMD_PROBE, KEY_ONES, '0, '0, '0, '0, FLAG_EXACT, '0);
		run_phase(1'b1, 12'h001);
		run_phase(1'b1, 12'hfff);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
